[rtl/gtg_pkg.sv]
// Package with shared types, constants and the CORDIC angle table.
package gtg_pkg;

    localparam int unsigned ATAN_LEN = 24;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;

    typedef enum logic [2:0] {
        REG_TARGET_X  = 3'd0,
        REG_TARGET_Y  = 3'd1,
        REG_GAIN      = 3'd2,
        REG_MAX_SPEED = 3'd3,
        REG_DIST_THR  = 3'd4,
        REG_ANG_THR   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [15:0] gain;
        logic [15:0] max_speed;
        logic [15:0] dist_thr;
        logic [14:0] ang_thr;
    } t_cfg;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [14:0] heading;
    } t_pose;

    typedef struct packed {
        logic [15:0] linear_speed;
        logic [14:0] angular_speed;
    } t_cmd;

    function automatic logic signed [19:0] atan_q16(input int unsigned i);
        logic signed [19:0] t;
        unique case (i)
            0: t = 20'sd51472;
            1: t = 20'sd30386;
            2: t = 20'sd16055;
            3: t = 20'sd8150;
            4: t = 20'sd4091;
            5: t = 20'sd2047;
            6: t = 20'sd1024;
            7: t = 20'sd512;
            8: t = 20'sd256;
            9: t = 20'sd128;
            10: t = 20'sd64;
            11: t = 20'sd32;
            12: t = 20'sd16;
            13: t = 20'sd8;
            14: t = 20'sd4;
            15: t = 20'sd2;
            16: t = 20'sd1;
            default: t = 20'sd0;
        endcase
        return t;
    endfunction

endpackage

[rtl/gtg_if.sv]
// Valid/ready stream interfaces for pose, command and configuration channels.
interface gtg_pose_if;
    logic           valid;
    logic           ready;
    gtg_pkg::t_pose data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtg_cmd_if;
    logic          valid;
    logic          ready;
    gtg_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/gtg_regs.sv]
// Configuration register file.
module gtg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gtg_cfg_if.sink        cfg,
    output gtg_pkg::t_cfg  o_cfg
);
    import gtg_pkg::*;

    t_cfg r_cfg;

    assign cfg.ready = 1'b1;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_x  <= 16'd0;
            r_cfg.target_y  <= 16'd0;
            r_cfg.gain      <= 16'd4096;
            r_cfg.max_speed <= 16'd12288;
            r_cfg.dist_thr  <= 16'd410;
            r_cfg.ang_thr   <= 15'd819;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                REG_TARGET_X:  r_cfg.target_x  <= cfg.wdata;
                REG_TARGET_Y:  r_cfg.target_y  <= cfg.wdata;
                REG_GAIN:      r_cfg.gain      <= cfg.wdata;
                REG_MAX_SPEED: r_cfg.max_speed <= cfg.wdata;
                REG_DIST_THR:  r_cfg.dist_thr  <= cfg.wdata;
                REG_ANG_THR:   r_cfg.ang_thr   <= cfg.wdata[14:0];
                default: ;
            endcase
        end
    end
endmodule

[rtl/gtg_datapath.sv]
// Pipelined datapath: deltas, CORDIC bearing, integer square root, decision.
module gtg_datapath #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  gtg_pkg::t_pose i_pose,
    input  gtg_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output gtg_pkg::t_cmd  o_cmd
);
    import gtg_pkg::*;

    // Square root: 17-bit root, one result bit per stage, 17 stages.
    localparam int SQ = 17;
    // CORDIC and root stages run side by side in parallel lanes.
    localparam int NS = (CORDIC_STAGES > SQ) ? CORDIC_STAGES : SQ;

    // Stage 0 registers.
    logic signed [16:0] r_dx, r_dy;
    logic signed [14:0] r_hd0;
    logic               r_v0;

    // CORDIC lanes, x up to ~2^30 scaled, 34 bits signed.
    logic signed [33:0] r_cx [NS+1];
    logic signed [33:0] r_cy [NS+1];
    logic signed [19:0] r_cz [NS+1];
    logic               r_zero [NS+1];
    logic signed [14:0] r_hd [NS+1];
    // Square root lanes.
    logic [33:0] r_rem [NS+1];
    logic [16:0] r_root [NS+1];
    logic [NS:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (i_en) r_v0 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= $signed({1'b0, i_cfg.target_x}) - $signed({1'b0, i_pose.pos_x});
            r_dy  <= $signed({1'b0, i_cfg.target_y}) - $signed({1'b0, i_pose.pos_y});
            r_hd0 <= i_pose.heading;
        end
    end

    // Stage 1: pre-rotation and squared magnitude.
    logic signed [33:0] n_px, n_py;
    logic signed [19:0] n_pz;
    always_comb begin
        logic signed [33:0] sx, sy;
        sx = {{5{r_dx[16]}}, r_dx, 12'd0};
        sy = {{5{r_dy[16]}}, r_dy, 12'd0};
        n_px = sx;
        n_py = sy;
        n_pz = 20'sd0;
        if (r_dx < 0) begin
            if (r_dy >= 0) begin
                n_px = sy; n_py = -sx; n_pz = HALF_PI_Q16;
            end else begin
                n_px = -sy; n_py = sx; n_pz = -HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= r_v0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]   <= n_px;
            r_cy[0]   <= n_py;
            r_cz[0]   <= n_pz;
            r_zero[0] <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
            r_hd[0]   <= r_hd0;
            r_rem[0]  <= 34'(r_dx * r_dx) + 34'(r_dy * r_dy);
            r_root[0] <= 17'd0;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic signed [33:0] n_x, n_y;
        logic signed [19:0] n_z;
        logic [33:0] n_rem;
        logic [16:0] n_root;
        logic [33:0] trial;
        always_comb begin
            n_x = r_cx[g];
            n_y = r_cy[g];
            n_z = r_cz[g];
            if (g < CORDIC_STAGES && g < ATAN_LEN) begin
                if (r_cy[g] >= 0) begin
                    n_x = r_cx[g] + (r_cy[g] >>> g);
                    n_y = r_cy[g] - (r_cx[g] >>> g);
                    n_z = r_cz[g] + atan_q16(g);
                end else begin
                    n_x = r_cx[g] - (r_cy[g] >>> g);
                    n_y = r_cy[g] + (r_cx[g] >>> g);
                    n_z = r_cz[g] - atan_q16(g);
                end
            end
            // Restoring root, bit SQ-1-g of the result.
            n_rem  = r_rem[g];
            n_root = r_root[g];
            trial  = '0;
            if (g < SQ) begin
                trial = ({17'd0, r_root[g]} << (SQ - g)) | (34'd1 << (2*(SQ-1-g)));
                if (r_rem[g] >= trial) begin
                    n_rem  = r_rem[g] - trial;
                    n_root = r_root[g] | (17'd1 << (SQ-1-g));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g+1] <= 1'b0;
            else if (i_en) r_v[g+1] <= r_v[g];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cx[g+1]   <= n_x;
                r_cy[g+1]   <= n_y;
                r_cz[g+1]   <= n_z;
                r_zero[g+1] <= r_zero[g];
                r_hd[g+1]   <= r_hd[g];
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= n_root;
            end
        end
    end

    // Stage A: round and clamp angle, subtract heading, absolute value.
    logic               r_va;
    logic [16:0]        r_dist;
    logic [15:0]        r_absb;
    logic signed [15:0] n_ang;
    logic signed [16:0] n_bear;
    always_comb begin
        logic signed [19:0] zr;
        zr = (r_cz[NS] + 20'sd8) >>> 4;
        if (zr > 20'(PI_Q12)) n_ang = PI_Q12;
        else if (zr < -20'(PI_Q12)) n_ang = -PI_Q12;
        else n_ang = zr[15:0];
        if (r_zero[NS]) n_ang = 16'sd0;
        n_bear = 17'(n_ang) - 17'(r_hd[NS]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (i_en) r_va <= r_v[NS];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= r_root[NS];
            r_absb <= n_bear[16] ? 16'(-n_bear) : n_bear[15:0];
        end
    end

    // Stage B: gain product and comparisons.
    logic        r_vb;
    logic [32:0] r_prod;
    logic        r_near, r_turn;
    logic [14:0] r_angb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (i_en) r_vb <= r_va;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_cfg.gain * r_dist;
            r_near <= r_dist <= {1'b0, i_cfg.dist_thr};
            r_turn <= r_absb > {1'b0, i_cfg.ang_thr};
            r_angb <= r_absb[14:0];
        end
    end

    // Stage C: clamp and select.
    logic  r_vc;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    always_comb begin
        logic [20:0] lin;
        lin   = r_prod[32:12];
        n_cmd = '0;
        if (!r_near) begin
            if (r_turn) n_cmd.angular_speed = r_angb;
            else if (lin > {5'd0, i_cfg.max_speed}) n_cmd.linear_speed = i_cfg.max_speed;
            else n_cmd.linear_speed = lin[15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (i_en) r_vc <= r_vb;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_vc;
    assign o_cmd   = r_cmd;
endmodule

[rtl/go_to_goal_steering.sv]
// Top level of the go-to-goal steering controller.
// Usage: poses arrive on the pose channel (pos_x, pos_y, heading), drive commands
// (linear_speed, angular_speed) leave on the command channel, one command per pose.
// Target, gain, speed clamp and thresholds are written on the configuration
// channel, which is always ready; writes to unknown indexes are dropped.
// Each transaction passes a pipeline of max(CORDIC_STAGES,17)+5 register stages:
// an input register for the deltas, a pre-rotation stage, the CORDIC and
// square-root lanes side by side (one iteration per stage), then angle rounding,
// the gain multiply and the final clamp. One pose is taken every cycle while the
// command channel is not stalled; the pipeline advances as a whole.
// When the receiver stalls with a command waiting, the whole pipeline holds
// and the pose channel drops ready; nothing is lost or repeated. Empty slots
// hold as well, so bubbles travel with the data and are not squeezed out.
// Reset, synchronous and active low, clears all valid bits and restores the
// register defaults (gain 1.0, max speed 3.0, stop distance 0.1, angle 0.2).
module go_to_goal_steering #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gtg_pose_if.sink   pose,
    gtg_cmd_if.source  cmd,
    gtg_cfg_if.sink    cfg
);
    import gtg_pkg::*;

    t_cfg w_cfg;
    logic w_en;

    gtg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg),
        .o_cfg   (w_cfg)
    );

    // The pipeline moves whenever the output slot is empty or being taken.
    assign w_en       = !cmd.valid || cmd.ready;
    assign pose.ready = w_en;

    gtg_datapath #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (pose.valid),
        .i_pose  (pose.data),
        .i_cfg   (w_cfg),
        .o_valid (cmd.valid),
        .o_cmd   (cmd.data)
    );

    // A waiting command holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid && !cmd.ready |=> cmd.valid && $stable(cmd.data))
        else $error("command changed under stall");
    // At most one of the two outputs is nonzero.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid |-> (cmd.data.linear_speed == 16'd0 || cmd.data.angular_speed == 15'd0))
        else $error("both outputs nonzero");
    // Stall backpressures the input.
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid && !cmd.ready |-> !pose.ready)
        else $error("pose accepted during stall");
endmodule
